@@ rtl/gcd_pkg.sv @@
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types and constants for the binary glTF container deframer.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // container constants, little-endian words
    localparam logic [31:0] GLB_MAGIC        = 32'h4654_6C67;
    localparam logic [31:0] GLB_JSON_TYPE    = 32'h4E4F_534A;
    localparam logic [31:0] GLB_BIN_TYPE     = 32'h004E_4942;
    localparam logic [31:0] GLB_HEADER_BYTES = 32'd12;
    localparam logic [31:0] GLB_VERSION      = 32'd2;

    // byte positions inside the file header
    localparam logic [31:0] POS_MAGIC_END   = 32'd3;
    localparam logic [31:0] POS_VERSION_END = 32'd7;
    localparam logic [31:0] POS_LENGTH_END  = 32'd11;

    // smallest tail that can still hold a chunk header
    localparam logic [31:0] CHUNK_HDR_BYTES = 32'd8;

    // tag of each output byte
    typedef enum logic [1:0] {
        KIND_HDR   = 2'd0,
        KIND_JSON  = 2'd1,
        KIND_BIN   = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    // status reported on the final byte
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_OVERRUN = 3'd5,
        ST_TRUNC   = 3'd6,
        ST_NO_JSON = 3'd7
    } status_t;

    // one result item
    typedef struct packed {
        logic [7:0] payload_byte;
        kind_t      byte_kind;
        logic       chunk_first;
        logic       done_res;
        status_t    status;
    } gcd_res_t;

endpackage

@@ rtl/gcd_parser.sv @@
// ----------------------------------------------------------------------------
// gcd_parser
// Parse state of the container and the per-byte step that tags each byte.
// ----------------------------------------------------------------------------
module gcd_parser
    import gcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output gcd_res_t   res
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_CLEN    = 3'd1,
        PH_CTYPE   = 3'd2,
        PH_FIRST   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_IGNORE  = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    logic [31:0] pos_reg,   pos_next;
    logic [31:0] dlen_reg,  dlen_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] crem_reg,  crem_next;
    logic [1:0]  ckind_reg, ckind_next;
    phase_t      phase_reg, phase_next;
    status_t     err_reg,   err_next;
    logic        json_reg,  json_next;

    logic [31:0] shifted;
    logic [31:0] left_hdr;
    logic [31:0] left_cur;
    logic [31:0] crem_dec;
    logic [32:0] pos_plus1;
    kind_t       type_kind;
    kind_t       out_kind;
    logic        out_first;
    status_t     out_status;

    // next state and result for one byte
    always_comb begin
        shifted    = {data_byte, shift_reg[31:8]};
        left_hdr   = shifted - pos_reg - 32'd1;
        left_cur   = dlen_reg - pos_reg - 32'd1;
        crem_dec   = (crem_reg != '0) ? crem_reg - 32'd1 : crem_reg;
        pos_plus1  = {1'b0, pos_reg} + 33'd1;
        type_kind  = KIND_OTHER;
        out_kind   = KIND_HDR;
        out_first  = 1'b0;
        out_status = ST_OK;

        pos_next   = pos_reg;
        dlen_next  = dlen_reg;
        shift_next = shift_reg;
        crem_next  = crem_reg;
        ckind_next = ckind_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        json_next  = json_reg;

        case (phase_reg)
            PH_HEADER: begin
                shift_next = shifted;
                if (pos_reg == POS_MAGIC_END && shifted != GLB_MAGIC) begin
                    if (err_reg == ST_OK) err_next = ST_MAGIC;
                    phase_next = PH_ERROR;
                end else if (pos_reg == POS_VERSION_END && shifted != GLB_VERSION) begin
                    if (err_reg == ST_OK) err_next = ST_VERSION;
                    phase_next = PH_ERROR;
                end else if (pos_reg >= POS_LENGTH_END) begin
                    dlen_next = shifted;
                    if (shifted < GLB_HEADER_BYTES || pos_reg >= shifted) begin
                        if (err_reg == ST_OK) err_next = ST_LENGTH;
                        phase_next = PH_ERROR;
                    end else begin
                        shift_next = '0;
                        ckind_next = '0;
                        phase_next = (left_hdr >= CHUNK_HDR_BYTES) ? PH_CLEN : PH_IGNORE;
                    end
                end
            end
            PH_CLEN: begin
                shift_next = shifted;
                if (ckind_reg == 2'd3) begin
                    crem_next  = shifted;
                    ckind_next = '0;
                    phase_next = PH_CTYPE;
                end else begin
                    ckind_next = ckind_reg + 2'd1;
                end
            end
            PH_CTYPE: begin
                shift_next = shifted;
                if (shifted == GLB_JSON_TYPE) begin
                    type_kind = KIND_JSON;
                end else if (shifted == GLB_BIN_TYPE) begin
                    type_kind = KIND_BIN;
                end
                if (ckind_reg == 2'd3) begin
                    if (pos_reg >= dlen_reg || crem_reg > left_cur) begin
                        if (err_reg == ST_OK) err_next = ST_OVERRUN;
                        phase_next = PH_ERROR;
                    end else begin
                        if (type_kind == KIND_JSON) begin
                            json_next = (crem_reg != '0);
                        end
                        if (crem_reg == '0) begin
                            shift_next = '0;
                            ckind_next = '0;
                            phase_next = (left_cur >= CHUNK_HDR_BYTES) ? PH_CLEN : PH_IGNORE;
                        end else begin
                            ckind_next = type_kind;
                            phase_next = PH_FIRST;
                        end
                    end
                end else begin
                    ckind_next = ckind_reg + 2'd1;
                end
            end
            PH_FIRST, PH_PAYLOAD: begin
                out_kind   = kind_t'(ckind_reg);
                out_first  = (phase_reg == PH_FIRST);
                phase_next = PH_PAYLOAD;
                crem_next  = crem_dec;
                if (crem_dec == '0) begin
                    if (pos_reg < dlen_reg) begin
                        shift_next = '0;
                        ckind_next = '0;
                        phase_next = (left_cur >= CHUNK_HDR_BYTES) ? PH_CLEN : PH_IGNORE;
                    end else begin
                        phase_next = PH_IGNORE;
                    end
                end
            end
            default: begin
            end
        endcase

        // saturating byte index
        if (pos_reg != '1) begin
            pos_next = pos_plus1[31:0];
        end

        // final byte: report status and return to reset
        if (last_byte) begin
            if (pos_reg < POS_LENGTH_END) begin
                out_status = ST_SHORT;
            end else if (err_next != ST_OK) begin
                out_status = err_next;
            end else if (pos_plus1 < {1'b0, dlen_next}) begin
                out_status = ST_TRUNC;
            end else if (!json_next) begin
                out_status = ST_NO_JSON;
            end else begin
                out_status = ST_OK;
            end
            pos_next   = '0;
            dlen_next  = '0;
            shift_next = '0;
            crem_next  = '0;
            ckind_next = '0;
            phase_next = PH_HEADER;
            err_next   = ST_OK;
            json_next  = 1'b0;
        end

        res.payload_byte = data_byte;
        res.byte_kind    = out_kind;
        res.chunk_first  = out_first;
        res.done_res     = last_byte;
        res.status       = out_status;
    end

    // parse state, advanced once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            dlen_reg  <= '0;
            shift_reg <= '0;
            crem_reg  <= '0;
            ckind_reg <= '0;
            phase_reg <= PH_HEADER;
            err_reg   <= ST_OK;
            json_reg  <= 1'b0;
        end else if (in_fire) begin
            pos_reg   <= pos_next;
            dlen_reg  <= dlen_next;
            shift_reg <= shift_next;
            crem_reg  <= crem_next;
            ckind_reg <= ckind_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
            json_reg  <= json_next;
        end
    end

endmodule

@@ rtl/gcd_out_stage.sv @@
// ----------------------------------------------------------------------------
// gcd_out_stage
// Result register on the master side; refills in the cycle it is taken.
// ----------------------------------------------------------------------------
module gcd_out_stage
    import gcd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  gcd_res_t res_in,
    output logic     ready,
    input  logic     take,
    output logic     valid,
    output gcd_res_t res_out
);

    logic     valid_reg, valid_next;
    gcd_res_t res_reg;

    // room when empty or the held result leaves this cycle
    assign ready      = !valid_reg || take;
    assign valid_next = load || (valid_reg && !take);
    assign valid      = valid_reg;
    assign res_out    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

@@ rtl/glb_container_deframer.sv @@
// ----------------------------------------------------------------------------
// glb_container_deframer
// Binary glTF container deframer: tags each file byte as header, JSON, BIN
// or other chunk payload and reports a status on the final byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_ side takes the file one byte per request (s_tdata), s_tlast on the
//   final byte. m_ side returns exactly one result per byte: the byte itself,
//   its kind and a first-of-chunk flag in m_tuser, the status in m_tdata and
//   m_tlast echoing the final-byte mark. Status is zero except with m_tlast.
//   The result is registered: a byte is on m_ in the cycle after it is taken.
//   Throughput is one byte per cycle while m_tready is high; the step is a
//   few 32-bit subtracts and compares between the parse state registers and
//   the result register. The result register refills in the same cycle it
//   is taken, so s_tready stays high while m_tready is high; when the
//   receiver stalls with a result held, s_tready drops until it is taken.
//   Reset (aresetn low, synchronous) empties the result register and puts
//   the parser at the start of a file; the final byte of each file also
//   returns the parser to that state. On any nonzero status the receiver
//   discards what it collected for that file.
// ----------------------------------------------------------------------------
module glb_container_deframer
    import gcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [10:8] status, rest zero
    output logic [2:0]  m_tuser,   // [1:0] byte_kind, [2] chunk_first
    output logic        m_tlast    // done_res
);

    logic     in_fire;
    logic     out_take;
    gcd_res_t step_res;
    gcd_res_t out_res;

    assign in_fire  = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    gcd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res       (step_res)
    );

    gcd_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (in_fire),
        .res_in  (step_res),
        .ready   (s_tready),
        .take    (out_take),
        .valid   (m_tvalid),
        .res_out (out_res)
    );

    // pack result fields onto the master side
    assign m_tdata = {5'd0, out_res.status, out_res.payload_byte};
    assign m_tuser = {out_res.chunk_first, out_res.byte_kind};
    assign m_tlast = out_res.done_res;

    // status only accompanies the final byte
    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[10:8] == ST_OK))
        else $error("status set on a byte that is not final");

    // a chunk start is always a payload byte
    a_first_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] != KIND_HDR))
        else $error("chunk start flagged on a header byte");

    // an empty result register never blocks the slave side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("slave side stalled with empty result register");

    // a byte taken always shows up on the master side next cycle
    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (m_tvalid && m_tdata[7:0] == $past(s_tdata)))
        else $error("accepted byte not presented next cycle");

endmodule
